@@ src/positional_list_store_core_defines.svh @@
// ----------------------------------------------------------------------------
// Positional list store assertion macros
// Short concurrent assertion forms shared by the files that check the store.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_STORE_CORE_DEFINES_SVH
`define POSITIONAL_LIST_STORE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define PLS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define PLS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/pls_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional list store package
// Transaction types, operation and status codes shared by the store files.
// ----------------------------------------------------------------------------
package pls_pkg;

  localparam int unsigned OP_W    = 3;
  localparam int unsigned POS_W   = 7;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned COUNT_W = 7;

  localparam logic [OP_W-1:0] OP_GET      = 3'd0;
  localparam logic [OP_W-1:0] OP_INS_HEAD = 3'd1;
  localparam logic [OP_W-1:0] OP_INS_TAIL = 3'd2;
  localparam logic [OP_W-1:0] OP_INS_AT   = 3'd3;
  localparam logic [OP_W-1:0] OP_DELETE   = 3'd4;

  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  // Value returned by a get whose position lies beyond the stored elements.
  localparam logic signed [VAL_W-1:0] READ_MISS = -32'sd1;

  typedef struct packed {
    logic [OP_W-1:0]         operation;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] read_value;
    logic [STAT_W-1:0]       status;
    logic [COUNT_W-1:0]      count;
  } out_item_t;

endpackage

@@ src/pls_idx_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional list store index unit
// Shared step-and-compare unit that walks the element index during a move.
// ----------------------------------------------------------------------------
module pls_idx_unit #(
  parameter int unsigned IW = 7
) (
  input  logic [IW-1:0] idx,
  input  logic [IW-1:0] bound,
  input  logic          step_down,
  output logic [IW-1:0] next_idx,
  output logic          more
);

  // Moving down continues while the index is above the bound; moving up
  // continues while the following index is still below it.
  assign next_idx = step_down ? (idx - IW'(1)) : (idx + IW'(1));
  assign more     = step_down ? (idx > bound) : (next_idx < bound);

endmodule

@@ src/positional_list_store_core.sv @@
`timescale 1ns / 1ps
`include "positional_list_store_core_defines.svh"
// ----------------------------------------------------------------------------
// Positional list store core
// Ordered store of signed 32-bit values with get, insert and delete by position.
// ----------------------------------------------------------------------------
//
// A request transaction is taken when start is high and busy is low; every
// request yields exactly one result transaction, shown for one cycle with
// out_valid, which the receiver must take there and then as it cannot stall
// the block. Elements live in a single-port-read, single-port-write memory,
// and inserts and deletes move the elements behind the position one at a
// time through that memory, with one read and one write for each element
// moved. Busy rises after acceptance for a get in range and for an insert or
// delete, which moves count - position elements for an insert and
// count - position - 1 for a delete, and does not rise for a rejected
// request or an unused operation code. Where busy rose, the result is shown
// in the cycle in which busy falls. A new request may be accepted in the
// cycle the previous result is shown.
//
module positional_list_store_core #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  pls_pkg::in_item_t  in_item,
  output logic              out_valid,
  output pls_pkg::out_item_t out_item
);

  import pls_pkg::*;

  // Element count needs to reach CAPACITY itself; the index is wide enough
  // for both the count and the request position so they compare directly.
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned IW = (CW > POS_W) ? CW : POS_W;
  localparam logic [IW-1:0] CAP_I = IW'(CAPACITY);

  // Sequencer states.
  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_GET_DATA = 3'd1;
  localparam logic [2:0] S_INS_RD   = 3'd2;
  localparam logic [2:0] S_INS_WR   = 3'd3;
  localparam logic [2:0] S_DEL_RD   = 3'd4;
  localparam logic [2:0] S_DEL_WR   = 3'd5;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [IW-1:0] pos_r, pos_nxt;
  logic signed [VAL_W-1:0] value_r, value_nxt;

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r, out_item_nxt;

  // Element memory: one write and one registered read per cycle.
  logic signed [VAL_W-1:0] mem [CAPACITY];
  logic signed [VAL_W-1:0] rdata_r;
  logic                    mem_re, mem_we;
  logic [AW-1:0]           rd_addr, wr_addr;
  logic signed [VAL_W-1:0] wr_data;

  // Shared index unit.
  logic [IW-1:0] unit_bound, unit_next;
  logic          unit_down, unit_more;

  logic          accept;
  logic [IW-1:0] count_i, in_pos_i, ins_pos;
  logic [IW-1:0] count_inc, count_dec;

  assign accept    = start && !busy;
  assign count_i   = IW'(count_r);
  assign in_pos_i  = IW'(in_item.position);
  assign count_inc = count_i + IW'(1);
  assign count_dec = count_i - IW'(1);

  // Inserts at the head and tail are inserts at a derived position.
  always_comb begin
    unique case (in_item.operation)
      OP_INS_HEAD: ins_pos = '0;
      OP_INS_TAIL: ins_pos = count_i;
      default:     ins_pos = in_pos_i;
    endcase
  end

  // An insert walks the index down to its position; a delete walks it up
  // towards the element count.
  assign unit_down  = (state_r == S_INS_RD) || (state_r == S_INS_WR);
  assign unit_bound = unit_down ? pos_r : count_i;

  pls_idx_unit #(
    .IW (IW)
  ) u_idx_unit (
    .idx       (idx_r),
    .bound     (unit_bound),
    .step_down (unit_down),
    .next_idx  (unit_next),
    .more      (unit_more)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    pos_nxt       = pos_r;
    value_nxt     = value_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    mem_re        = 1'b0;
    mem_we        = 1'b0;
    rd_addr       = unit_next[AW-1:0];
    wr_addr       = idx_r[AW-1:0];
    wr_data       = rdata_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_item_nxt.read_value = '0;
          out_item_nxt.status     = ST_DONE;
          out_item_nxt.count      = count_i[COUNT_W-1:0];
          unique case (in_item.operation)
            OP_GET: begin
              if (in_pos_i < count_i) begin
                // Read issued now; the data is registered for the next cycle.
                mem_re    = 1'b1;
                rd_addr   = in_pos_i[AW-1:0];
                state_nxt = S_GET_DATA;
              end else begin
                out_item_nxt.read_value = READ_MISS;
                out_item_nxt.status     = ST_RANGE;
                out_valid_nxt           = 1'b1;
              end
            end
            OP_INS_HEAD, OP_INS_TAIL, OP_INS_AT: begin
              // A position past the end is reported before a full store.
              if (ins_pos > count_i) begin
                out_item_nxt.status = ST_RANGE;
                out_valid_nxt       = 1'b1;
              end else if (count_i == CAP_I) begin
                out_item_nxt.status = ST_FULL;
                out_valid_nxt       = 1'b1;
              end else begin
                idx_nxt   = count_i;
                pos_nxt   = ins_pos;
                value_nxt = in_item.value;
                state_nxt = S_INS_RD;
              end
            end
            OP_DELETE: begin
              if (in_pos_i < count_i) begin
                idx_nxt   = in_pos_i;
                state_nxt = S_DEL_RD;
              end else begin
                out_item_nxt.status = ST_RANGE;
                out_valid_nxt       = 1'b1;
              end
            end
            default: begin
              // Unused codes leave the store as it is.
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      S_GET_DATA: begin
        out_item_nxt.read_value = rdata_r;
        out_valid_nxt           = 1'b1;
        state_nxt               = S_IDLE;
      end
      S_INS_RD: begin
        if (unit_more) begin
          mem_re    = 1'b1;
          state_nxt = S_INS_WR;
        end else begin
          // Gap is open at the insert position: drop the new value in.
          mem_we             = 1'b1;
          wr_addr            = pos_r[AW-1:0];
          wr_data            = value_r;
          count_nxt          = count_inc[CW-1:0];
          out_item_nxt.count = count_inc[COUNT_W-1:0];
          out_valid_nxt      = 1'b1;
          state_nxt          = S_IDLE;
        end
      end
      S_INS_WR: begin
        mem_we    = 1'b1;
        idx_nxt   = unit_next;
        state_nxt = S_INS_RD;
      end
      S_DEL_RD: begin
        if (unit_more) begin
          mem_re    = 1'b1;
          state_nxt = S_DEL_WR;
        end else begin
          count_nxt          = count_dec[CW-1:0];
          out_item_nxt.count = count_dec[COUNT_W-1:0];
          out_valid_nxt      = 1'b1;
          state_nxt          = S_IDLE;
        end
      end
      S_DEL_WR: begin
        mem_we    = 1'b1;
        idx_nxt   = unit_next;
        state_nxt = S_DEL_RD;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    pos_r      <= pos_nxt;
    value_r    <= value_nxt;
    out_item_r <= out_item_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (mem_re) begin
      rdata_r <= mem[rd_addr];
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // The element count never passes the capacity.
  `PLS_ASSERT_IMP(a_count_bound, 1'b1, count_i <= CAP_I, "element count above capacity")
  // A result only follows an accepted request or a finishing sequence.
  `PLS_ASSERT_NXT(a_no_spurious_result, (state_r == S_IDLE) && !accept, !out_valid_r,
                  "result without a request")
  // A move during an insert never writes past the last entry.
  `PLS_ASSERT_IMP(a_ins_write_bound, state_r == S_INS_WR, idx_r < CAP_I,
                  "insert move beyond capacity")
  // The count only changes where an insert or delete finishes.
  `PLS_ASSERT_NXT(a_count_stable, (state_r != S_INS_RD) && (state_r != S_DEL_RD),
                  $stable(count_r), "element count changed outside a finish step")

endmodule
